// ===== rtl/core/twbc_pkg.sv =====
// Shared constants and types for the tile window box collision block.
`timescale 1ns / 1ps

package twbc_pkg;

	// Field widths
	localparam int POS_W  = 16;	// world coordinates, signed
	localparam int TS_W   = 8;	// tile size register
	localparam int MAPD_W = 7;	// map size registers, window bounds
	localparam int IDX_W  = 6;	// tile_col / tile_row ports
	localparam int KIND_W = 8;
	localparam int BOX_W  = POS_W + 2;	// box edges after offsets

	// Parameter defaults
	localparam int DEF_MAX_COLS      = 64;
	localparam int DEF_MAX_ROWS      = 64;
	localparam int DEF_WINDOW_RADIUS = 2;

	// Configuration register indexes
	localparam logic [1:0] CFG_TILE_SIZE  = 2'd0;
	localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

	localparam logic [TS_W-1:0]   TILE_SIZE_RST  = 8'd32;
	localparam logic [MAPD_W-1:0] MAP_WIDTH_RST  = 7'd64;
	localparam logic [MAPD_W-1:0] MAP_HEIGHT_RST = 7'd64;

	// Solid tile kinds
	localparam logic [KIND_W-1:0] SOLID_KIND_A = 8'd5;
	localparam logic [KIND_W-1:0] SOLID_KIND_B = 8'd6;

	// Player hitbox geometry
	localparam int PLAYER_OFF_X = 17;
	localparam int PLAYER_OFF_Y = 22;
	localparam int PLAYER_W     = 34;
	localparam int PLAYER_H     = 30;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [POS_W-1:0] corner_x;
		logic signed [POS_W-1:0] corner_y;
	} tile_entry_t;

endpackage

// ===== rtl/core/twbc_div.sv =====
// Serial signed floor divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module twbc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [twbc_pkg::POS_W-1:0] dividend,
	input  logic [twbc_pkg::TS_W-1:0]         divisor,
	output logic                              done,
	output logic signed [twbc_pkg::POS_W-1:0] quotient
);
	import twbc_pkg::*;

	localparam int CNT_W = $clog2(POS_W);

	logic                    run_q;
	logic                    fin_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic [POS_W-1:0]        mag_q;
	logic [TS_W-1:0]         rem_q;
	logic [TS_W-1:0]         div_q;
	logic signed [POS_W-1:0] quot_q;

	logic [POS_W-1:0] dividend_u;
	logic [POS_W-1:0] abs_val;
	logic [TS_W:0]    trial;
	logic [TS_W:0]    diff;
	logic             ge;
	logic [TS_W-1:0]  rem_next;
	logic [POS_W:0]   neg_full;

	assign dividend_u = dividend;
	assign abs_val    = dividend[POS_W-1] ? (~dividend_u + 1'b1) : dividend_u;
	assign trial      = {rem_q, mag_q[POS_W-1]};
	assign diff       = trial - {1'b0, div_q};
	assign ge         = trial >= {1'b0, div_q};
	assign rem_next   = ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
	// floor for negative dividends: -(q) - (remainder != 0)
	assign neg_full   = {(POS_W+1){1'b0}} - {1'b0, mag_q} - (POS_W+1)'(rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(POS_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[POS_W-1];
			mag_q <= abs_val;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[POS_W-2:0], ge};
			rem_q <= rem_next;
		end else if (fin_q) begin
			quot_q <= neg_q ? neg_full[POS_W-1:0] : mag_q;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q && !fin_q)
		else $error("divider done while still working");

	a_run_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !start |=> run_q || fin_q)
		else $error("divider run ended without finish step");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> done_q)
		else $error("divider finish step gave no done");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q && !fin_q)
		else $error("divider restarted mid-operation");

endmodule

// ===== rtl/core/tile_window_box_collision.sv =====
// Top level: tile store, window sequencer and box-overlap test.
//
// Channel   Direction  Handshake                 Beat contents
// --------  ---------  ------------------------  ------------------------------------
// command   in         start & !busy             action, tile_*, player_x/y
// result    out        done strobe, one cycle    hit
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A tile write leaves busy low. A query holds busy while the shared serial divider
// works (x then y) and the single store read port reads N window cells (at most
// (2*WINDOW_RADIUS)^2), one cell per cycle, stopping at the first hit.
// Reset clears the sequencer and loads config reset values; the store is not cleared.
// done comes out of a register for one cycle; hit comes out of a register that holds
// until the next result. The receiver cannot stall.
`timescale 1ns / 1ps

module tile_window_box_collision #(
	parameter int MAX_COLS      = twbc_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS      = twbc_pkg::DEF_MAX_ROWS,
	parameter int WINDOW_RADIUS = twbc_pkg::DEF_WINDOW_RADIUS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic [twbc_pkg::IDX_W-1:0]         tile_col,
	input  logic [twbc_pkg::IDX_W-1:0]         tile_row,
	input  logic [twbc_pkg::KIND_W-1:0]        tile_kind,
	input  logic signed [twbc_pkg::POS_W-1:0]  tile_world_x,
	input  logic signed [twbc_pkg::POS_W-1:0]  tile_world_y,
	input  logic signed [twbc_pkg::POS_W-1:0]  player_x,
	input  logic signed [twbc_pkg::POS_W-1:0]  player_y,
	output logic                               done,
	output logic                               hit,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [twbc_pkg::TS_W-1:0]          cfg_data
);
	import twbc_pkg::*;

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIVX  = 3'd1;
	localparam logic [2:0] ST_DIVY  = 3'd2;
	localparam logic [2:0] ST_WIN   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	function automatic logic [MAPD_W-1:0] clamp_win(input logic signed [POS_W:0] v,
			input logic [MAPD_W-1:0] lim);
		logic signed [POS_W:0] lim_s;
		lim_s = {{(POS_W+1-MAPD_W){1'b0}}, lim};
		if (v < 0)
			return '0;
		else if (v > lim_s)
			return lim;
		else
			return v[MAPD_W-1:0];
	endfunction

	// Config registers
	logic [TS_W-1:0]   tile_size_q;
	logic [MAPD_W-1:0] map_width_q;
	logic [MAPD_W-1:0] map_height_q;

	// Sequencer
	logic [2:0] state_q;
	logic       done_q;
	logic       hit_q;
	logic       rd_vld_q;

	// Query payload
	logic signed [BOX_W-1:0] bx_q, bxr_q, by_q, byb_q;
	logic signed [POS_W-1:0] py_q;
	logic [TS_W-2:0]         half_q;
	logic [MAPD_W-1:0]       xs_q, xe_q, ys_q, ye_q;
	logic [MAPD_W-1:0]       row_q, col_q;

	// Tile store
	tile_entry_t tile_mem [DEPTH];
	tile_entry_t rd_data_q;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              mem_we;

	logic              accept, q_accept;
	logic [TS_W-1:0]   ts_eff;
	logic [MAPD_W-1:0] w_eff, h_eff;
	logic              div_start, div_done;
	logic signed [POS_W-1:0] div_dividend, div_quot;
	logic signed [POS_W:0]   lo_val, hi_val;
	logic [MAPD_W-1:0] lo_x, hi_x, lo_y, hi_y;
	logic              last_col, last_row;
	logic signed [BOX_W-1:0] tx, ty, tx_end, ty_end;
	logic              solid, overlap, tile_hit;

	assign accept   = start && !busy;
	assign q_accept = accept && action;
	assign busy     = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;

	assign ts_eff = (tile_size_q == '0) ? TS_W'(1) : tile_size_q;
	assign w_eff  = (32'(map_width_q) > MAX_COLS) ? MAPD_W'(MAX_COLS) : map_width_q;
	assign h_eff  = (32'(map_height_q) > MAX_ROWS) ? MAPD_W'(MAX_ROWS) : map_height_q;

	// Divider is shared: x on query accept, y right after x finishes
	assign div_start    = q_accept || (state_q == ST_DIVX && div_done);
	assign div_dividend = (state_q == ST_IDLE) ? player_x : py_q;

	twbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (ts_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign lo_val = {div_quot[POS_W-1], div_quot} - (POS_W+1)'(WINDOW_RADIUS);
	assign hi_val = {div_quot[POS_W-1], div_quot} + (POS_W+1)'(WINDOW_RADIUS);
	assign lo_x   = clamp_win(lo_val, w_eff);
	assign hi_x   = clamp_win(hi_val, w_eff);
	assign lo_y   = clamp_win(lo_val, h_eff);
	assign hi_y   = clamp_win(hi_val, h_eff);

	assign last_col = (col_q + 1'b1) == xe_q;
	assign last_row = (row_q + 1'b1) == ye_q;

	// Overlap test on the entry read in the previous cycle
	assign tx      = BOX_W'(rd_data_q.corner_x);
	assign ty      = BOX_W'(rd_data_q.corner_y);
	assign tx_end  = tx + $signed({{(BOX_W-TS_W+1){1'b0}}, half_q});
	assign ty_end  = ty + $signed({{(BOX_W-TS_W+1){1'b0}}, half_q});
	assign solid   = (rd_data_q.kind == SOLID_KIND_A) || (rd_data_q.kind == SOLID_KIND_B);
	assign overlap = (tx < bxr_q) && (bx_q < tx_end) && (ty < byb_q) && (by_q < ty_end);
	assign tile_hit = rd_vld_q && solid && overlap;

	assign mem_we  = accept && !action && (32'(tile_col) < MAX_COLS)
		&& (32'(tile_row) < MAX_ROWS);
	assign wr_addr = ADDR_W'(tile_row) * ADDR_W'(MAX_COLS) + ADDR_W'(tile_col);
	assign rd_addr = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			tile_mem[wr_addr] <= '{kind: tile_kind, corner_x: tile_world_x,
				corner_y: tile_world_y};
		if (state_q == ST_SCAN)
			rd_data_q <= tile_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q  <= TILE_SIZE_RST;
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TILE_SIZE:  tile_size_q  <= cfg_data;
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data[MAPD_W-1:0];
				CFG_MAP_HEIGHT: map_height_q <= cfg_data[MAPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			rd_vld_q <= (state_q == ST_SCAN) && !tile_hit;
			unique case (state_q)
				ST_IDLE: begin
					if (q_accept)
						state_q <= ST_DIVX;
				end
				ST_DIVX: begin
					if (div_done)
						state_q <= ST_DIVY;
				end
				ST_DIVY: begin
					if (div_done)
						state_q <= ST_WIN;
				end
				ST_WIN: begin
					if (xs_q == xe_q || ys_q == ye_q) begin
						done_q  <= 1'b1;
						hit_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tile_hit) begin
						done_q  <= 1'b1;
						hit_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else if (last_col && last_row) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					done_q  <= 1'b1;
					hit_q   <= tile_hit;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_accept) begin
			bx_q   <= BOX_W'(player_x) - BOX_W'(PLAYER_OFF_X);
			bxr_q  <= BOX_W'(player_x) - BOX_W'(PLAYER_OFF_X) + BOX_W'(PLAYER_W);
			by_q   <= BOX_W'(player_y) + BOX_W'(PLAYER_OFF_Y);
			byb_q  <= BOX_W'(player_y) + BOX_W'(PLAYER_OFF_Y) + BOX_W'(PLAYER_H);
			py_q   <= player_y;
			half_q <= ts_eff[TS_W-1:1];
		end
		if (state_q == ST_DIVX && div_done) begin
			xs_q <= lo_x;
			xe_q <= hi_x;
		end
		if (state_q == ST_DIVY && div_done) begin
			ys_q <= lo_y;
			ye_q <= hi_y;
		end
		if (state_q == ST_WIN) begin
			row_q <= ys_q;
			col_q <= xs_q;
		end else if (state_q == ST_SCAN) begin
			if (last_col) begin
				col_q <= xs_q;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign hit  = hit_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result beat while query still in progress");

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (row_q < ye_q) && (col_q < xe_q) && (col_q >= xs_q))
		else $error("scan address left the window");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVX || state_q == ST_DIVY)
		else $error("divider finished outside a divide step");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_IDLE)
		else $error("tile store written during a query");

endmodule
